// ===== hw/rtl/ptm_pkg.sv =====
// ptm_pkg: shared constants, op codes, controller states and the command and
// status structs used between the timer manager controller and datapath.
// no dependencies
`timescale 1ns / 1ps

package ptm_pkg;

    // sizing
    localparam int NUM_TIMERS   = 16;
    localparam int TIME_BITS    = 48;
    localparam int ID_BITS      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int SCAN_BITS    = $clog2(NUM_TIMERS + 1);

    // field widths
    localparam int OP_BITS      = 2;
    localparam int ITEM_ID_BITS = 4;
    localparam int PERIOD_BITS  = 16;
    localparam int OUT_ID_BITS  = 4;
    localparam int STEP_BITS    = 10;
    localparam int S_DATA_BITS  = 24;
    localparam int M_DATA_BITS  = 8;

    // arithmetic constants
    localparam int US_PER_MS    = 1000;
    localparam int MS_MUL_BITS  = 10;
    localparam int PROD_BITS    = PERIOD_BITS + MS_MUL_BITS;
    localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(1000);

    typedef enum logic [OP_BITS-1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_STOP,
        ST_START_MUL,
        ST_START_WR,
        ST_ADVANCE,
        ST_DUE_SCAN,
        ST_SEL_START,
        ST_SEL_SCAN,
        ST_SEL_PER,
        ST_SEL_MUL,
        ST_EMIT
    } ctl_state_t;

    typedef struct packed {
        logic load;        // latch the input transaction
        logic disarm;      // stop: clear armed bit
        logic mul;         // register period * 1000
        logic mul_stored;  // 1: period from store, 0: from item
        logic arm_write;   // start: write deadline and period, set armed
        logic advance;     // now += step, clear due flags, reset scan
        logic scan_reset;  // restart slot scan and best tracking
        logic scan_step;   // one slot scan step
        logic scan_select; // 1: best search, 0: due evaluation
        logic emit;        // write result, advance best deadline
    } ptm_cmd_t;

    typedef struct packed {
        logic [OP_BITS-1:0] item_op;
        logic               scan_done;
        logic               any_due;
        logic               out_free;
    } ptm_status_t;

endpackage

// ===== hw/rtl/ptm_ram.sv =====
// ptm_ram: generic single write, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module ptm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/ptm_ctrl.sv =====
// ptm_ctrl: sequencing state machine of the timer manager
// depends on ptm_pkg
`timescale 1ns / 1ps

module ptm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  ptm_pkg::ptm_status_t status,
    output ptm_pkg::ptm_cmd_t    cmd
);

    ptm_pkg::ctl_state_t state_reg;
    ptm_pkg::ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ptm_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ptm_pkg::ST_DECODE;
                end
            end
            ptm_pkg::ST_DECODE:
            begin
                priority case (status.item_op)
                    ptm_pkg::OP_TICK:  state_next = ptm_pkg::ST_ADVANCE;
                    ptm_pkg::OP_START: state_next = ptm_pkg::ST_START_MUL;
                    ptm_pkg::OP_STOP:  state_next = ptm_pkg::ST_STOP;
                    default:           state_next = ptm_pkg::ST_IDLE;
                endcase
            end
            ptm_pkg::ST_STOP:      state_next = ptm_pkg::ST_IDLE;
            ptm_pkg::ST_START_MUL: state_next = ptm_pkg::ST_START_WR;
            ptm_pkg::ST_START_WR:  state_next = ptm_pkg::ST_IDLE;
            ptm_pkg::ST_ADVANCE:   state_next = ptm_pkg::ST_DUE_SCAN;
            ptm_pkg::ST_DUE_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ptm_pkg::ST_SEL_START;
                end
            end
            ptm_pkg::ST_SEL_START:
            begin
                state_next = status.any_due ? ptm_pkg::ST_SEL_SCAN : ptm_pkg::ST_IDLE;
            end
            ptm_pkg::ST_SEL_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ptm_pkg::ST_SEL_PER;
                end
            end
            ptm_pkg::ST_SEL_PER:   state_next = ptm_pkg::ST_SEL_MUL;
            ptm_pkg::ST_SEL_MUL:   state_next = ptm_pkg::ST_EMIT;
            ptm_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ptm_pkg::ST_SEL_START;
                end
            end
            default:               state_next = ptm_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ptm_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ptm_pkg::ST_STOP:      cmd.disarm = 1'b1;
            ptm_pkg::ST_START_MUL: cmd.mul = 1'b1;
            ptm_pkg::ST_START_WR:  cmd.arm_write = 1'b1;
            ptm_pkg::ST_ADVANCE:   cmd.advance = 1'b1;
            ptm_pkg::ST_DUE_SCAN:  cmd.scan_step = 1'b1;
            ptm_pkg::ST_SEL_START: cmd.scan_reset = 1'b1;
            ptm_pkg::ST_SEL_SCAN:
            begin
                cmd.scan_step   = 1'b1;
                cmd.scan_select = 1'b1;
            end
            ptm_pkg::ST_SEL_MUL:
            begin
                cmd.mul        = 1'b1;
                cmd.mul_stored = 1'b1;
            end
            ptm_pkg::ST_EMIT:      cmd.emit = status.out_free;
            default:
            begin
                cmd      = '0;
                s_tready = 1'b0;
            end
        endcase
    end

    ap_load_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ptm_pkg::ST_DECODE))
        else $error("accepted transaction not decoded");

    ap_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("result written into an occupied output register");

endmodule

// ===== hw/rtl/ptm_datapath.sv =====
// ptm_datapath: time base, armed and due flags, deadline and period stores,
// slot scan engine, best-deadline search and output register
// depends on ptm_pkg and ptm_ram
`timescale 1ns / 1ps

module ptm_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ptm_pkg::STEP_BITS-1:0]     cfg_wdata,
    input  logic [ptm_pkg::S_DATA_BITS-1:0]   s_tdata,
    input  logic [ptm_pkg::OP_BITS-1:0]       s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ptm_pkg::M_DATA_BITS-1:0]   m_tdata,
    output logic                              m_tlast,
    input  ptm_pkg::ptm_cmd_t                 cmd,
    output ptm_pkg::ptm_status_t              status
);

    localparam int TB = ptm_pkg::TIME_BITS;
    localparam int IB = ptm_pkg::ID_BITS;
    localparam int NT = ptm_pkg::NUM_TIMERS;

    logic [ptm_pkg::STEP_BITS-1:0]    step_reg;
    logic [TB-1:0]                    now_reg;
    logic [NT-1:0]                    armed_reg;
    logic [NT-1:0]                    due_reg;

    logic [ptm_pkg::OP_BITS-1:0]      op_reg;
    logic [ptm_pkg::ITEM_ID_BITS-1:0] id_reg;
    logic [ptm_pkg::PERIOD_BITS-1:0]  per_reg;
    logic [ptm_pkg::PROD_BITS-1:0]    prod_reg;

    logic [ptm_pkg::SCAN_BITS-1:0]    scan_idx_reg;
    logic                             rd_pend_reg;
    logic [IB-1:0]                    rd_idx_reg;

    logic [IB-1:0]                    best_reg;
    logic [TB-1:0]                    best_late_reg;
    logic [TB-1:0]                    best_dl_reg;
    logic                             found_reg;

    logic                             out_valid_reg;
    logic [ptm_pkg::OUT_ID_BITS-1:0]  out_id_reg;
    logic                             out_last_reg;

    logic [IB-1:0]                    item_slot;
    logic                             item_in_range;
    logic [TB-1:0]                    dl_rdata;
    logic [ptm_pkg::PERIOD_BITS-1:0]  per_rdata;
    logic [TB-1:0]                    late;
    logic                             dl_we;
    logic [IB-1:0]                    dl_waddr;
    logic [TB-1:0]                    dl_wdata;
    logic [IB-1:0]                    scan_addr;
    logic                             scan_more;
    logic [NT-1:0]                    best_mask;
    logic [ptm_pkg::PERIOD_BITS-1:0]  mul_src;

    assign item_slot     = IB'(id_reg);
    assign item_in_range = (32'(id_reg) < 32'(NT));
    assign scan_addr     = scan_idx_reg[IB-1:0];
    assign scan_more     = (32'(scan_idx_reg) < 32'(NT));
    assign late          = now_reg - dl_rdata;
    assign best_mask     = {{(NT-1){1'b0}}, 1'b1} << best_reg;
    assign mul_src       = cmd.mul_stored ? per_rdata : per_reg;

    // shared deadline write port: start arms, emit advances
    assign dl_we    = (cmd.arm_write && item_in_range && !armed_reg[item_slot]) || cmd.emit;
    assign dl_waddr = cmd.emit ? best_reg : item_slot;
    assign dl_wdata = cmd.emit ? (best_dl_reg + TB'(prod_reg)) : (now_reg + TB'(prod_reg));

    ptm_ram #(
        .WIDTH (TB),
        .DEPTH (NT)
    ) u_deadline_ram (
        .clk   (clk),
        .we    (dl_we),
        .waddr (dl_waddr),
        .wdata (dl_wdata),
        .raddr (scan_addr),
        .rdata (dl_rdata)
    );

    ptm_ram #(
        .WIDTH (ptm_pkg::PERIOD_BITS),
        .DEPTH (NT)
    ) u_period_ram (
        .clk   (clk),
        .we    (cmd.arm_write && item_in_range && !armed_reg[item_slot]),
        .waddr (item_slot),
        .wdata (per_reg),
        .raddr (best_reg),
        .rdata (per_rdata)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ptm_pkg::STEP_RESET;
            now_reg       <= '0;
            armed_reg     <= '0;
            due_reg       <= '0;
            scan_idx_reg  <= '0;
            rd_pend_reg   <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                step_reg <= cfg_wdata;
            end
            if (cmd.disarm && item_in_range)
            begin
                armed_reg[item_slot] <= 1'b0;
            end
            if (cmd.arm_write && item_in_range)
            begin
                armed_reg[item_slot] <= 1'b1;
            end
            if (cmd.advance)
            begin
                now_reg <= now_reg + TB'(step_reg);
                due_reg <= '0;
            end
            if (cmd.advance || cmd.scan_reset)
            begin
                scan_idx_reg <= '0;
                rd_pend_reg  <= 1'b0;
                found_reg    <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                rd_pend_reg <= scan_more;
                if (scan_more)
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
                if (rd_pend_reg)
                begin
                    if (!cmd.scan_select)
                    begin
                        due_reg[rd_idx_reg] <= armed_reg[rd_idx_reg] && !late[TB-1];
                    end
                    else if (due_reg[rd_idx_reg] && (!found_reg || late > best_late_reg))
                    begin
                        found_reg <= 1'b1;
                    end
                end
            end
            if (cmd.emit)
            begin
                due_reg[best_reg] <= 1'b0;
                out_valid_reg     <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= s_tuser;
            id_reg  <= s_tdata[ptm_pkg::ITEM_ID_BITS-1:0];
            per_reg <= s_tdata[ptm_pkg::ITEM_ID_BITS +: ptm_pkg::PERIOD_BITS];
        end
        if (cmd.mul)
        begin
            prod_reg <= ptm_pkg::PROD_BITS'(mul_src) *
                        ptm_pkg::PROD_BITS'(ptm_pkg::US_PER_MS);
        end
        if (cmd.scan_step && scan_more)
        begin
            rd_idx_reg <= scan_addr;
        end
        if (cmd.scan_step && cmd.scan_select && rd_pend_reg && due_reg[rd_idx_reg]
            && (!found_reg || late > best_late_reg))
        begin
            best_reg      <= rd_idx_reg;
            best_late_reg <= late;
            best_dl_reg   <= dl_rdata;
        end
        if (cmd.emit)
        begin
            out_id_reg   <= ptm_pkg::OUT_ID_BITS'(best_reg);
            out_last_reg <= ((due_reg & ~best_mask) == '0);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = ptm_pkg::M_DATA_BITS'(out_id_reg);
    assign m_tlast  = out_last_reg;

    assign status.item_op   = op_reg;
    assign status.scan_done = !scan_more && !rd_pend_reg;
    assign status.any_due   = (due_reg != '0);
    assign status.out_free  = !out_valid_reg || m_tready;

    ap_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> m_tvalid)
        else $error("emitted result not presented");

    ap_emit_clears_due: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> !due_reg[$past(best_reg)])
        else $error("reported slot still flagged due");

    ap_emit_found: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> found_reg)
        else $error("result emitted with no slot selected");

    ap_time_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.advance |=> $stable(now_reg))
        else $error("time base moved outside a tick");

endmodule

// ===== hw/rtl/periodic_timer_manager.sv =====
// periodic_timer_manager: top level of the periodic timer slot manager
// depends on ptm_pkg, ptm_ctrl, ptm_datapath (which uses ptm_ram)
`timescale 1ns / 1ps

// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+---------------------------------------
// s_axis    | in        | s_tvalid / s_tready  | tuser: op; tdata: timer_id, period_ms
// m_axis    | out       | m_tvalid / m_tready  | tdata: expired_id; tlast: last
// cfg       | in        | cfg_we               | cfg_wdata: tick_step_us
//
// a stop passes through decode and stop, and a start through decode, multiply and
// write, from acceptance to the next ready; a tick advances time, scans all slots for
// due timers, then walks the one read port of the deadline store once per expiry
// reset clears time, armed flags and the output register; stores need no clear
// a stalled result holds in the output register; the search waits only when the
// next result is ready and the register is still full

module periodic_timer_manager (
    input  logic                            clk,
    input  logic                            rst_n,

    // configuration: tick step in microseconds
    input  logic                            cfg_we,
    input  logic [ptm_pkg::STEP_BITS-1:0]   cfg_wdata,

    // input transactions
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ptm_pkg::S_DATA_BITS-1:0] s_tdata,   // [3:0] timer_id, [19:4] period_ms
    input  logic [ptm_pkg::OP_BITS-1:0]     s_tuser,   // [1:0] op

    // expiry transactions
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ptm_pkg::M_DATA_BITS-1:0] m_tdata,   // [3:0] expired_id
    output logic                            m_tlast
);

    ptm_pkg::ptm_cmd_t    cmd;
    ptm_pkg::ptm_status_t status;

    // sequencer: decodes the op and walks the tick through due scan and
    // repeated best-deadline searches
    ptm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // storage, arithmetic and output register
    ptm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
